[hdl/tlfc_pkg.sv]
// Shared types and constants for the limited face correction pipeline.
// No dependencies; tlfc_front, tlfc_back and the top level use it by scoped names.
`default_nettype none

package tlfc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 2;

    localparam logic [CFG_W-1:0] LIM_MINMOD   = 2'd0;
    localparam logic [CFG_W-1:0] LIM_VANLEER  = 2'd1;
    localparam logic [CFG_W-1:0] LIM_SUPERBEE = 2'd2;
    // Unused selector code; it behaves as minmod.
    localparam logic [CFG_W-1:0] LIM_SPARE    = 2'd3;

    typedef struct packed {
        logic signed [31:0] normal_velocity;
        logic        [30:0] area;
        logic signed [31:0] phi_owner;
        logic signed [31:0] phi_neighbour;
        logic signed [31:0] grad_x_owner;
        logic signed [31:0] grad_y_owner;
        logic signed [31:0] grad_x_neighbour;
        logic signed [31:0] grad_y_neighbour;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic               last_face;
    } t_face_in;

    typedef struct packed {
        logic signed [31:0] correction;
        logic               last_out;
    } t_face_out;

endpackage

`default_nettype wire

[hdl/tlfc_front.sv]
// Front end: flux magnitude, upwind selection, gradient projection and divider operands.
// Four register stages. Depends on tlfc_pkg for the input beat type.
`default_nettype none

module tlfc_front #(
    parameter int FRAC_BITS = tlfc_pkg::FRAC_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  tlfc_pkg::t_face_in       i_face,
    output logic                     o_valid,
    output logic [32+FRAC_BITS:0]    o_num,
    output logic [63-FRAC_BITS:0]    o_den,
    output logic signed [32:0]       o_ddn,
    output logic [61-FRAC_BITS:0]    o_mag,
    output logic                     o_pos,
    output logic                     o_sat,
    output logic                     o_last
);

    localparam int MAG_W = 62 - FRAC_BITS;
    localparam int DEN_W = 64 - FRAC_BITS;
    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int SUM_W = 65 - FRAC_BITS;
    localparam int CW    = DEN_W + 31;

    // Stage 1: products and value difference.
    logic signed [31:0] w_u;
    logic               w_owner_up;
    logic        [31:0] w_umag;
    logic signed [31:0] w_gx;
    logic signed [31:0] w_gy;
    logic signed [63:0] n_px;
    logic signed [63:0] n_py;
    logic        [62:0] n_mprod;
    logic signed [32:0] n_ddn;

    logic signed [63:0] r1_px;
    logic signed [63:0] r1_py;
    logic        [62:0] r1_mprod;
    logic signed [32:0] r1_ddn;
    logic               r1_owner_up;
    logic               r1_last;
    logic               r1_vld;

    assign w_u        = i_face.normal_velocity;
    assign w_owner_up = !w_u[31] || (i_face.area == '0);
    assign w_umag     = w_u[31] ? 32'(-w_u) : 32'(w_u);
    assign w_gx       = w_owner_up ? i_face.grad_x_owner : i_face.grad_x_neighbour;
    assign w_gy       = w_owner_up ? i_face.grad_y_owner : i_face.grad_y_neighbour;
    assign n_px       = 64'(w_gx) * 64'(i_face.offset_x);
    assign n_py       = 64'(w_gy) * 64'(i_face.offset_y);
    assign n_mprod    = 63'(w_umag) * 63'(i_face.area);
    assign n_ddn      = w_owner_up ? (33'(i_face.phi_neighbour) - 33'(i_face.phi_owner))
                                   : (33'(i_face.phi_owner) - 33'(i_face.phi_neighbour));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px       <= n_px;
            r1_py       <= n_py;
            r1_mprod    <= n_mprod;
            r1_ddn      <= n_ddn;
            r1_owner_up <= w_owner_up;
            r1_last     <= i_face.last_face;
        end
    end

    // Stage 2: floored projections summed, flux magnitude scaled.
    logic signed [SUM_W-1:0] n_sum;
    logic        [MAG_W-1:0] n_mag;

    logic signed [SUM_W-1:0] r2_sum;
    logic        [MAG_W-1:0] r2_mag;
    logic signed [32:0]      r2_ddn;
    logic                    r2_owner_up;
    logic                    r2_last;
    logic                    r2_vld;

    assign n_sum = SUM_W'(r1_px >>> FRAC_BITS) + SUM_W'(r1_py >>> FRAC_BITS);
    assign n_mag = MAG_W'(r1_mprod >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sum      <= n_sum;
            r2_mag      <= n_mag;
            r2_ddn      <= r1_ddn;
            r2_owner_up <= r1_owner_up;
            r2_last     <= r1_last;
        end
    end

    // Stage 3: magnitudes for the divider and the sign test on the ratio.
    logic               w_sneg;
    logic               w_snz;
    logic               w_dupneg;
    logic               w_dneg;
    logic        [32:0] w_ddn_abs;
    logic [DEN_W-1:0]   n_den;
    logic [NUM_W-1:0]   n_num;
    logic               n_pos;

    logic [DEN_W-1:0]   r3_den;
    logic [NUM_W-1:0]   r3_num;
    logic               r3_pos;
    logic        [MAG_W-1:0] r3_mag;
    logic signed [32:0] r3_ddn;
    logic               r3_last;
    logic               r3_vld;

    assign w_sneg    = r2_sum[SUM_W-1];
    assign w_snz     = (r2_sum != '0);
    // The sign of the upwind projection flips when the neighbour is upwind.
    assign w_dupneg  = r2_owner_up ? w_sneg : (w_snz && !w_sneg);
    assign w_dneg    = r2_ddn[32];
    assign w_ddn_abs = w_dneg ? 33'(-r2_ddn) : 33'(r2_ddn);
    assign n_den     = DEN_W'(w_sneg ? -r2_sum : r2_sum);
    assign n_num     = {w_ddn_abs, FRAC_BITS'(0)};
    assign n_pos     = w_snz && (r2_ddn != '0) && (w_dneg == w_dupneg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_den  <= n_den;
            r3_num  <= n_num;
            r3_pos  <= n_pos;
            r3_mag  <= r2_mag;
            r3_ddn  <= r2_ddn;
            r3_last <= r2_last;
        end
    end

    // Stage 4: the quotient saturates when it would reach 2^31.
    logic n_sat;

    logic [DEN_W-1:0]   r4_den;
    logic [NUM_W-1:0]   r4_num;
    logic               r4_pos;
    logic               r4_sat;
    logic        [MAG_W-1:0] r4_mag;
    logic signed [32:0] r4_ddn;
    logic               r4_last;
    logic               r4_vld;

    assign n_sat = (CW'(r3_num) >= (CW'(r3_den) << 31));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_den  <= r3_den;
            r4_num  <= r3_num;
            r4_pos  <= r3_pos;
            r4_sat  <= n_sat;
            r4_mag  <= r3_mag;
            r4_ddn  <= r3_ddn;
            r4_last <= r3_last;
        end
    end

    assign o_valid = r4_vld;
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_ddn   = r4_ddn;
    assign o_mag   = r4_mag;
    assign o_pos   = r4_pos;
    assign o_sat   = r4_sat;
    assign o_last  = r4_last;

endmodule

`default_nettype wire

[hdl/tlfc_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Generic widths with a sideband payload; no package dependencies.
`default_nettype none

module tlfc_div #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 48,
    parameter int Q_BITS = 31,
    parameter int SIDE_W = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire  [NUM_W-1:0]     i_num,
    input  wire  [DEN_W-1:0]     i_den,
    input  wire  [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [Q_BITS-1:0]    o_q,
    output logic [SIDE_W-1:0]    o_side
);

    // The caller guarantees num < den * 2^Q_BITS, or ignores the quotient.
    localparam int CW = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

    logic [NUM_W-1:0]  r_rem  [Q_BITS];
    logic [DEN_W-1:0]  r_den  [Q_BITS];
    logic [Q_BITS-1:0] r_q    [Q_BITS];
    logic [SIDE_W-1:0] r_side [Q_BITS];
    logic              r_vld  [Q_BITS];

    for (genvar s = 0; s < Q_BITS; s++) begin : g_stg
        logic [NUM_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [Q_BITS-1:0] w_q;
        logic [SIDE_W-1:0] w_side;
        logic              w_vld;
        logic [CW-1:0]     w_trial;
        logic [CW-1:0]     w_diff;
        logic              w_ge;
        logic [NUM_W-1:0]  n_rem;
        logic [Q_BITS-1:0] n_q;

        if (s == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_q    = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[s-1];
            assign w_den  = r_den[s-1];
            assign w_q    = r_q[s-1];
            assign w_side = r_side[s-1];
            assign w_vld  = r_vld[s-1];
        end

        assign w_trial = CW'(w_den) << (Q_BITS - 1 - s);
        assign w_ge    = (CW'(w_rem) >= w_trial);
        assign w_diff  = CW'(w_rem) - w_trial;
        assign n_rem   = w_ge ? w_diff[NUM_W-1:0] : w_rem;
        assign n_q     = {w_q[Q_BITS-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= w_den;
                r_q[s]    <= n_q;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[Q_BITS-1];
    assign o_q     = r_q[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

`default_nettype wire

[hdl/tlfc_rsat.sv]
// Ratio resolve stage: saturation and sign gating of r, van Leer operands, clamp to one.
// One register stage; no package dependencies.
`default_nettype none

module tlfc_rsat #(
    parameter int FRAC_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire  [30:0]              i_q,
    input  wire                      i_pos,
    input  wire                      i_sat,
    input  wire  signed [32:0]       i_ddn,
    input  wire  [61-FRAC_BITS:0]    i_mag,
    input  wire                      i_last,
    output logic                     o_valid,
    output logic [31+FRAC_BITS:0]    o_vnum,
    output logic [31:0]              o_vden,
    output logic [FRAC_BITS:0]       o_m,
    output logic signed [32:0]       o_ddn,
    output logic [61-FRAC_BITS:0]    o_mag,
    output logic                     o_last
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic [30:0]            w_r;
    logic [31+FRAC_BITS:0]  n_vnum;
    logic [31:0]            n_vden;
    logic [FRAC_BITS:0]     n_m;

    logic                   r_vld;
    logic [31+FRAC_BITS:0]  r_vnum;
    logic [31:0]            r_vden;
    logic [FRAC_BITS:0]     r_m;
    logic signed [32:0]     r_ddn;
    logic [61-FRAC_BITS:0]  r_mag;
    logic                   r_last;

    // A non-positive ratio makes every limiter zero, so it is carried as zero.
    assign w_r    = !i_pos ? '0 : (i_sat ? '1 : i_q);
    assign n_vnum = {w_r, (FRAC_BITS + 1)'(0)};
    assign n_vden = 32'(w_r) + ONE;
    assign n_m    = (32'(w_r) >= ONE) ? (FRAC_BITS + 1)'(ONE) : (FRAC_BITS + 1)'(w_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vnum <= n_vnum;
            r_vden <= n_vden;
            r_m    <= n_m;
            r_ddn  <= i_ddn;
            r_mag  <= i_mag;
            r_last <= i_last;
        end
    end

    assign o_valid = r_vld;
    assign o_vnum  = r_vnum;
    assign o_vden  = r_vden;
    assign o_m     = r_m;
    assign o_ddn   = r_ddn;
    assign o_mag   = r_mag;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[hdl/tlfc_back.sv]
// Back end: limiter select, psi times the value difference, times flux magnitude,
// floor and saturate. Six register stages, the last is the output register. Depends on tlfc_pkg.
`default_nettype none

module tlfc_back #(
    parameter int FRAC_BITS = tlfc_pkg::FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire  [tlfc_pkg::CFG_W-1:0] i_sel,
    input  wire  [FRAC_BITS:0]         i_vq,
    input  wire  [FRAC_BITS:0]         i_m,
    input  wire  signed [32:0]         i_ddn,
    input  wire  [61-FRAC_BITS:0]      i_mag,
    input  wire                        i_last,
    output logic                       o_valid,
    output tlfc_pkg::t_face_out        o_result
);

    localparam int MAG_W = 62 - FRAC_BITS;
    localparam int PSI_W = FRAC_BITS + 2;
    localparam int TF_W  = FRAC_BITS + 36;
    localparam int MH    = (MAG_W + 1) / 2;
    localparam int HI_W  = MAG_W - MH;
    localparam int PW    = 34 + MAG_W;
    localparam int QW    = PW - FRAC_BITS - 1;

    // Stage 1: limiter value.
    logic [PSI_W-1:0]   n_psi;
    logic [PSI_W-1:0]   r1_psi;
    logic signed [32:0] r1_ddn;
    logic [MAG_W-1:0]   r1_mag;
    logic               r1_last;
    logic               r1_vld;

    always_comb begin
        unique case (i_sel)
            tlfc_pkg::LIM_VANLEER:  n_psi = PSI_W'(i_vq);
            tlfc_pkg::LIM_SUPERBEE: n_psi = {i_m, 1'b0};
            tlfc_pkg::LIM_MINMOD:   n_psi = PSI_W'(i_m);
            default:                n_psi = PSI_W'(i_m);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_psi  <= n_psi;
            r1_ddn  <= i_ddn;
            r1_mag  <= i_mag;
            r1_last <= i_last;
        end
    end

    // Stage 2: psi times the value difference.
    logic signed [TF_W-1:0] n_tf;
    logic signed [TF_W-1:0] r2_tf;
    logic [MAG_W-1:0]       r2_mag;
    logic                   r2_last;
    logic                   r2_vld;

    assign n_tf = TF_W'(signed'({1'b0, r1_psi})) * TF_W'(r1_ddn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_tf   <= n_tf;
            r2_mag  <= r1_mag;
            r2_last <= r1_last;
        end
    end

    // Stage 3: floor by the fraction width, split into sign and magnitude.
    logic signed [34:0] w_t;
    logic [33:0]        n_tm;
    logic [33:0]        r3_tm;
    logic               r3_tneg;
    logic [MAG_W-1:0]   r3_mag;
    logic               r3_last;
    logic               r3_vld;

    assign w_t  = 35'(r2_tf >>> FRAC_BITS);
    assign n_tm = w_t[34] ? 34'(-w_t) : 34'(w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tm   <= n_tm;
            r3_tneg <= w_t[34];
            r3_mag  <= r2_mag;
            r3_last <= r2_last;
        end
    end

    // Stage 4: partial products against the two halves of the flux magnitude.
    logic [33+MH:0]   n_plo;
    logic [33+HI_W:0] n_phi;
    logic [33+MH:0]   r4_plo;
    logic [33+HI_W:0] r4_phi;
    logic             r4_tneg;
    logic             r4_last;
    logic             r4_vld;

    assign n_plo = (34 + MH)'(r3_tm) * (34 + MH)'(r3_mag[MH-1:0]);
    assign n_phi = (34 + HI_W)'(r3_tm) * (34 + HI_W)'(r3_mag[MAG_W-1:MH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_plo  <= n_plo;
            r4_phi  <= n_phi;
            r4_tneg <= r3_tneg;
            r4_last <= r3_last;
        end
    end

    // Stage 5: full magnitude product.
    logic [PW-1:0] n_p;
    logic [PW-1:0] r5_p;
    logic          r5_tneg;
    logic          r5_last;
    logic          r5_vld;

    assign n_p = PW'(r4_plo) + (PW'(r4_phi) << MH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_p    <= n_p;
            r5_tneg <= r4_tneg;
            r5_last <= r4_last;
        end
    end

    // Stage 6: halve and floor, then saturate. A negative value floors away from
    // zero, so any dropped fraction bit adds one to the magnitude.
    logic [QW-1:0]         w_qv;
    logic                  w_any;
    logic [QW:0]           w_nmag;
    logic signed [31:0]    n_corr;
    tlfc_pkg::t_face_out   r_out;
    logic                  r_out_vld;

    assign w_qv   = r5_p[PW-1:FRAC_BITS+1];
    assign w_any  = |r5_p[FRAC_BITS:0];
    assign w_nmag = {1'b0, w_qv} + (QW + 1)'(w_any);

    always_comb begin
        if (!r5_tneg) begin
            n_corr = (w_qv > QW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : signed'(w_qv[31:0]);
        end else begin
            n_corr = (w_nmag > (QW + 1)'(32'h8000_0000)) ? 32'sh8000_0000
                                                          : signed'(32'(-w_nmag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.correction <= n_corr;
            r_out.last_out   <= r5_last;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

[hdl/tvd_limited_face_correction.sv]
// Values have FRAC_BITS fraction bits (Q16.16 by default). Throughput: one face per
// cycle while the output is not stalled; the 31-stage ratio divider and the van Leer
// divider resolve one quotient bit per stage, which sets the depth, not the rate.
// Reset: synchronous, active low; clears all stage valid bits and sets the limiter
// to minmod. No memory and no clearing pass, so input is taken right after reset.
`default_nettype none

module tvd_limited_face_correction #(
    parameter int FRAC_BITS = tlfc_pkg::FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  tlfc_pkg::t_face_in         i_face,
    output logic                       o_stall,
    output logic                       o_valid,
    output tlfc_pkg::t_face_out        o_result,
    input  wire                        i_stall,
    input  wire                        i_cfg_valid,
    input  wire  [tlfc_pkg::CFG_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);

    localparam int MAG_W  = 62 - FRAC_BITS;
    localparam int DEN_W  = 64 - FRAC_BITS;
    localparam int NUM_W  = 33 + FRAC_BITS;
    localparam int RS_W   = 33 + MAG_W + 3;
    localparam int VNUM_W = 32 + FRAC_BITS;
    localparam int VQ     = FRAC_BITS + 1;
    localparam int VS_W   = VQ + 33 + MAG_W + 1;

    // The whole pipeline moves as one. It halts only when a result beat sits in the
    // output register and the consumer stalls it; bubbles move otherwise.
    logic w_en;
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    // Limiter select. Users must write only while the pipeline is empty; unenforced.
    logic [tlfc_pkg::CFG_W-1:0] r_lim;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= tlfc_pkg::LIM_MINMOD;
        end else if (i_cfg_valid) begin
            r_lim <= i_cfg_data;
        end
    end

    // Front end: flux, upwind choice, upwind projection and value difference,
    // divider operands.
    logic                     w_front_vld;
    logic [NUM_W-1:0]         w_num;
    logic [DEN_W-1:0]         w_den;
    logic signed [32:0]       w_ddn;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_pos;
    logic                     w_sat;
    logic                     w_last;

    tlfc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_face  (i_face),
        .o_valid (w_front_vld),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_ddn   (w_ddn),
        .o_mag   (w_mag),
        .o_pos   (w_pos),
        .o_sat   (w_sat),
        .o_last  (w_last)
    );

    // Ratio divider: |value difference| * 2^FRAC_BITS over |upwind projection|,
    // 31 quotient bits. Saturated ratios are flagged up front and their quotient
    // is discarded.
    logic              w_rdiv_vld;
    logic [30:0]       w_rq;
    logic [RS_W-1:0]   w_rside;
    logic signed [32:0] w_rddn;
    logic [MAG_W-1:0]  w_rmag;
    logic              w_rpos;
    logic              w_rsat;
    logic              w_rlast;

    tlfc_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_BITS (31),
        .SIDE_W (RS_W)
    ) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  ({w_ddn, w_mag, w_pos, w_sat, w_last}),
        .o_valid (w_rdiv_vld),
        .o_q     (w_rq),
        .o_side  (w_rside)
    );

    assign {w_rddn, w_rmag, w_rpos, w_rsat, w_rlast} = w_rside;

    // Resolve r and prepare 2r*one / (one + r) for van Leer.
    logic                w_rs_vld;
    logic [VNUM_W-1:0]   w_vnum;
    logic [31:0]         w_vden;
    logic [VQ-1:0]       w_m;
    logic signed [32:0]  w_sddn;
    logic [MAG_W-1:0]    w_smag;
    logic                w_slast;

    tlfc_rsat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rsat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rdiv_vld),
        .i_q     (w_rq),
        .i_pos   (w_rpos),
        .i_sat   (w_rsat),
        .i_ddn   (w_rddn),
        .i_mag   (w_rmag),
        .i_last  (w_rlast),
        .o_valid (w_rs_vld),
        .o_vnum  (w_vnum),
        .o_vden  (w_vden),
        .o_m     (w_m),
        .o_ddn   (w_sddn),
        .o_mag   (w_smag),
        .o_last  (w_slast)
    );

    // Van Leer divider. Every beat passes through it so all limiters share one
    // latency; the result is used only when van Leer is selected.
    logic               w_vdiv_vld;
    logic [VQ-1:0]      w_vq;
    logic [VS_W-1:0]    w_vside;
    logic [VQ-1:0]      w_vm;
    logic signed [32:0] w_vddn;
    logic [MAG_W-1:0]   w_vmag;
    logic               w_vlast;

    tlfc_div #(
        .NUM_W  (VNUM_W),
        .DEN_W  (32),
        .Q_BITS (VQ),
        .SIDE_W (VS_W)
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rs_vld),
        .i_num   (w_vnum),
        .i_den   (w_vden),
        .i_side  ({w_m, w_sddn, w_smag, w_slast}),
        .o_valid (w_vdiv_vld),
        .o_q     (w_vq),
        .o_side  (w_vside)
    );

    assign {w_vm, w_vddn, w_vmag, w_vlast} = w_vside;

    // Back end: psi, the two products, floor and saturation, output register.
    tlfc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_vdiv_vld),
        .i_sel    (r_lim),
        .i_vq     (w_vq),
        .i_m      (w_vm),
        .i_ddn    (w_vddn),
        .i_mag    (w_vmag),
        .i_last   (w_vlast),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // Input is held off only while a result beat waits on a stalled consumer.
    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result beat");

    // A reset cycle leaves no result beat behind it.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present right after reset");

    // While the pipeline is frozen, front end and ratio divider keep their occupancy.
    a_freeze_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_front_vld) && $stable(w_rdiv_vld))
        else $error("pipeline stage moved during a stall");
`endif

endmodule

`default_nettype wire

[verif/tlfc_checker.sv]
// Checker for the limited face correction pipeline: watches the face, result and
// limiter channels, predicts every correction and compares it. Depends on tlfc_pkg.
`timescale 1ns / 1ps

module tlfc_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_face_valid,
    input  wire                        i_face_stall,
    input  tlfc_pkg::t_face_in         i_face,
    input  wire                        i_result_valid,
    input  wire                        i_result_stall,
    input  tlfc_pkg::t_face_out        i_result,
    input  wire                        i_cfg_valid,
    input  wire                        i_cfg_ready,
    input  wire  [tlfc_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_results
);

    localparam int FB = tlfc_pkg::FRAC_BITS_DEF;

    logic [tlfc_pkg::CFG_W-1:0] limiter_mode;
    tlfc_pkg::t_face_out        expected_results[$];

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint limit_ratio(input longint r,
                                           input logic [tlfc_pkg::CFG_W-1:0] mode);
        longint one;
        longint a;
        longint b;
        one = longint'(1) << FB;
        if (r <= 0) return 0;
        if (mode == tlfc_pkg::LIM_VANLEER) return (2 * r * one) / (one + r);
        if (mode == tlfc_pkg::LIM_SUPERBEE) begin
            a = (2 * r < 2 * one) ? 2 * r : 2 * one;
            b = (r < 2 * one) ? r : 2 * one;
            return (a > b) ? a : b;
        end
        // Minmod, and the unused selector code falls back to it as well.
        return (r < one) ? r : one;
    endfunction

    function automatic tlfc_pkg::t_face_out predict_correction(
        input tlfc_pkg::t_face_in         f,
        input logic [tlfc_pkg::CFG_W-1:0] mode
    );
        tlfc_pkg::t_face_out res;
        longint    u;
        longint    area;
        longint    flux_mag;
        logic      owner_up;
        longint    grad_dot;
        longint    diff;
        longint    ratio;
        longint    psi;
        longint    t;
        longint    t_mag;
        longint    prod;
        longint    corr;
        u        = longint'(f.normal_velocity);
        area     = longint'({1'b0, f.area});
        flux_mag = (((u < 0) ? -u : u) * area) >>> FB;
        owner_up = (u >= 0) || (area == 0);
        if (owner_up) begin
            grad_dot = ((longint'(f.grad_x_owner) * longint'(f.offset_x)) >>> FB)
                     + ((longint'(f.grad_y_owner) * longint'(f.offset_y)) >>> FB);
            diff     = longint'(f.phi_neighbour) - longint'(f.phi_owner);
        end else begin
            grad_dot = -(((longint'(f.grad_x_neighbour) * longint'(f.offset_x)) >>> FB)
                     + ((longint'(f.grad_y_neighbour) * longint'(f.offset_y)) >>> FB));
            diff     = longint'(f.phi_owner) - longint'(f.phi_neighbour);
        end
        ratio = 0;
        if (grad_dot != 0) ratio = sat_word((diff * (longint'(1) << FB)) / grad_dot);
        psi   = limit_ratio(ratio, mode);
        t     = (psi * diff) >>> FB;
        t_mag = (t < 0) ? -t : t;
        if (t_mag != 0 && flux_mag > (longint'(1) << 62) / t_mag) begin
            corr = (t < 0) ? -64'sd2147483648 : 64'sd2147483647;
        end else begin
            prod = t_mag * flux_mag;
            corr = sat_word(((t < 0) ? -prod : prod) >>> (FB + 1));
        end
        res.correction = corr[31:0];
        res.last_out   = f.last_face;
        return res;
    endfunction

    always @(posedge i_clk) begin
        tlfc_pkg::t_face_out exp_res;
        if (!i_rst_n) begin
            limiter_mode <= tlfc_pkg::LIM_MINMOD;
            o_mismatches <= 0;
            o_results    <= 0;
            o_pending    <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                limiter_mode <= i_cfg_data;
            end
            if (i_face_valid && !i_face_stall) begin
                expected_results.push_back(predict_correction(i_face, limiter_mode));
            end
            if (i_result_valid && !i_result_stall) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%0t: result beat with nothing expected: corr %0d last %0b",
                                 $realtime, i_result.correction, i_result.last_out);
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.correction !== i_result.correction
                            || exp_res.last_out !== i_result.last_out) begin
                        if (o_mismatches < 10) begin
                            $display("%0t: correction expected %0d last %0b, got %0d last %0b",
                                     $realtime, exp_res.correction, exp_res.last_out,
                                     i_result.correction, i_result.last_out);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

[verif/tvd_limited_face_correction_test.sv]
// Top of the limited face correction testbench: clock, reset, face stimulus, receiver
// stalls, limiter writes and the verdict. Depends on tlfc_pkg, tlfc_checker and the DUT.
`timescale 1ns / 1ps

module tvd_limited_face_correction_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;   // comfortably above the pipeline latency
    localparam int HOLD_CYCLES    = 300;  // long output hold that backs up the pipeline

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    tlfc_pkg::t_face_in         i_face;
    logic                       o_stall;
    logic                       o_valid;
    tlfc_pkg::t_face_out        o_result;
    logic                       i_stall;
    logic                       i_cfg_valid;
    logic [tlfc_pkg::CFG_W-1:0] i_cfg_data;
    logic                       o_cfg_ready;

    int mismatches;
    int pending;
    int results;

    // Idle rates in percent for each side; the stimulus process changes them per phase.
    int send_idle_pct;
    int recv_idle_pct;
    // Each increment of hold_token asks the receiver process for one long hold.
    int hold_token;
    int idle_cycles;

    tvd_limited_face_correction u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_face     (i_face),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_stall    (i_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready)
    );

    tlfc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_face_valid  (i_valid),
        .i_face_stall  (o_stall),
        .i_face        (i_face),
        .i_result_valid(o_valid),
        .i_result_stall(i_stall),
        .i_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver side. A hold request turns into a long unbroken stall that is counted
    // here, while the face side keeps offering beats, so the pipeline fills and the
    // block has to push back on its input.
    always @(posedge i_clk) begin
        int hold_seen;
        int hold_left;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_seen  = 0;
            hold_left  = 0;
        end else if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            hold_left  = HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic tlfc_pkg::t_face_in make_face(
        input logic signed [31:0] u,
        input logic signed [31:0] area,
        input logic signed [31:0] phi_o,
        input logic signed [31:0] phi_n,
        input logic signed [31:0] gx_o,
        input logic signed [31:0] gy_o,
        input logic signed [31:0] gx_n,
        input logic signed [31:0] gy_n,
        input logic signed [31:0] off_x,
        input logic signed [31:0] off_y,
        input logic               last
    );
        tlfc_pkg::t_face_in f;
        f.normal_velocity  = u;
        f.area             = area[30:0];
        f.phi_owner        = phi_o;
        f.phi_neighbour    = phi_n;
        f.grad_x_owner     = gx_o;
        f.grad_y_owner     = gy_o;
        f.grad_x_neighbour = gx_n;
        f.grad_y_neighbour = gy_n;
        f.offset_x         = off_x;
        f.offset_y         = off_y;
        f.last_face        = last;
        return f;
    endfunction

    function automatic logic signed [31:0] rand_span(input int bits);
        return $signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
    endfunction

    // Mostly physically plausible faces, whose ratios land around the limiter knees;
    // some with flat gradients, some with zero area, some with every field fully random.
    function automatic tlfc_pkg::t_face_in random_face();
        tlfc_pkg::t_face_in f;
        int                 kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end else begin
            f = make_face(rand_span(21), 32'($urandom_range(1 << 20)),
                          rand_span(21), rand_span(21),
                          rand_span(19), rand_span(19), rand_span(19), rand_span(19),
                          rand_span(18), rand_span(18), 1'b0);
            if (kind == 1) begin
                f.grad_x_owner     = '0;
                f.grad_y_owner     = '0;
                f.grad_x_neighbour = '0;
                f.grad_y_neighbour = '0;
            end else if (kind == 2) begin
                f.area = '0;
            end
        end
        f.last_face = ($urandom_range(15) == 0);
        return f;
    endfunction

    // Offers one face and returns once it is accepted. Valid is left high so that
    // back-to-back faces need no second assignment in the same step.
    task automatic send_face(input tlfc_pkg::t_face_in f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_face  <= f;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limiter(input logic [tlfc_pkg::CFG_W-1:0] mode);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_directed();
        localparam logic signed [31:0] ONE  = 32'sh0001_0000;
        localparam logic signed [31:0] MAXS = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINS = 32'sh8000_0000;
        localparam logic signed [31:0] AMAX = 32'sh7FFF_FFFF;
        // All zero.
        send_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        // Owner upwind, r of exactly one.
        send_face(make_face(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE, 0, 1'b0));
        // Neighbour upwind, mirrored.
        send_face(make_face(-ONE, ONE, ONE, 0, 0, 0, ONE, 0, -ONE, 0, 1'b0));
        // Negative velocity over a zero area keeps the owner upwind.
        send_face(make_face(-ONE, 0, 0, ONE, ONE, 0, -ONE, 0, ONE, 0, 1'b0));
        // Zero upwind gradient gives a zero ratio.
        send_face(make_face(ONE, ONE, 0, 3 * ONE, 0, 0, ONE, ONE, ONE, ONE, 1'b0));
        // Ratio below, near and above the limiter knees.
        send_face(make_face(ONE, 4 * ONE, 0, ONE / 4, ONE, 0, 0, 0, ONE, 0, 1'b0));
        send_face(make_face(ONE, 4 * ONE, 0, ONE / 2, ONE, 0, 0, 0, ONE, 0, 1'b0));
        send_face(make_face(ONE, 4 * ONE, 0, 3 * ONE / 2, ONE, 0, 0, 0, ONE, 0, 1'b0));
        send_face(make_face(ONE, 4 * ONE, 0, 3 * ONE, ONE, 0, 0, 0, ONE, 0, 1'b0));
        // Negative ratio.
        send_face(make_face(ONE, ONE, ONE, 0, ONE, ONE, 0, 0, ONE, ONE, 1'b0));
        // Large difference over a tiny gradient that floors to zero: the ratio is zero.
        send_face(make_face(ONE, ONE, MINS, MAXS, 1, 0, 0, 0, 1, 0, 1'b0));
        // Huge products, positive then negative, saturating the correction.
        send_face(make_face(MAXS, AMAX, MINS, MAXS, 2, 0, 0, 0, MAXS, 0, 1'b0));
        send_face(make_face(MINS, AMAX, MINS, MAXS, 0, 0, -2, 0, MINS, 0, 1'b1));
        send_face(make_face(MAXS, AMAX, MAXS, MINS, MINS, MINS, 0, 0, MAXS, MAXS, 1'b0));
        // All fields at top, then at bottom, then at bottom but area and phi_n at top.
        send_face(make_face(MAXS, AMAX, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, 1'b1));
        send_face(make_face(MINS, 0, MINS, MINS, MINS, MINS, MINS, MINS, MINS, MINS, 1'b0));
        send_face(make_face(MINS, AMAX, MINS, MAXS, MINS, MINS, MINS, MINS, MINS, MINS, 1'b1));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_face        = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = tlfc_pkg::LIM_MINMOD;
        send_idle_pct = 12;
        recv_idle_pct = 53;
        hold_token    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed faces under the reset limiter and under every selector code,
        // the unused one included.
        send_directed();
        write_limiter(tlfc_pkg::LIM_VANLEER);
        send_directed();
        write_limiter(tlfc_pkg::LIM_SUPERBEE);
        send_directed();
        write_limiter(tlfc_pkg::LIM_SPARE);
        send_directed();

        // Random phases: six segments over the three idling mixes, each segment
        // under another limiter.
        for (int seg = 0; seg < 6; seg++) begin
            unique case (seg % 4)
                0: write_limiter(tlfc_pkg::LIM_MINMOD);
                1: write_limiter(tlfc_pkg::LIM_VANLEER);
                2: write_limiter(tlfc_pkg::LIM_SUPERBEE);
                default: write_limiter(tlfc_pkg::LIM_SPARE);
            endcase
            if (seg < 2) begin
                send_idle_pct = 12;
                recv_idle_pct = 53;
            end else if (seg < 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 245; n++) begin
                if (seg == 4 && n == 20) hold_token = hold_token + 1;
                send_face(random_face());
            end
        end
        drain();

        $display("Checked %0d corrections over all limiter codes, three idling mixes", results);
        $display("and a %0d-cycle output hold that backed up the pipeline.", HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
